### src/dbl_pkg.sv
// Package for the dual button debounce and LED toggle block.
// Holds command and result codes, LED codes, word types and the debounce step.
// No dependencies.
package dbl_pkg;

	localparam logic [2:0] FUNC_TICK        = 3'd0;
	localparam logic [2:0] FUNC_SET_BOTH    = 3'd1;
	localparam logic [2:0] FUNC_SET_ONE     = 3'd2;
	localparam logic [2:0] FUNC_GET_LEDS    = 3'd3;
	localparam logic [2:0] FUNC_GET_BUTTONS = 3'd4;

	localparam logic [2:0] KIND_ACK         = 3'd0;
	localparam logic [2:0] KIND_INVALID     = 3'd1;
	localparam logic [2:0] KIND_UNSUPPORTED = 3'd2;
	localparam logic [2:0] KIND_LEDS        = 3'd3;
	localparam logic [2:0] KIND_BUTTONS     = 3'd4;
	localparam logic [2:0] KIND_EVENT       = 3'd5;

	localparam logic [1:0] LED_AT_ON  = 2'd0;
	localparam logic [1:0] LED_AT_OFF = 2'd1;
	localparam logic [1:0] LED_ON     = 2'd2;

	localparam logic [7:0] SEL_LEFT  = 8'd0;
	localparam logic [7:0] SEL_RIGHT = 8'd1;

	localparam logic [7:0] DEBOUNCE_RESET = 8'd10;
	localparam logic       BTN_RELEASED   = 1'b1;
	localparam logic       BTN_PRESSED    = 1'b0;

	typedef struct packed {
		logic [2:0] func;
		logic       calc_phase;
		logic       message_phase;
		logic       pin_right;
		logic       pin_left;
		logic [7:0] req_led_right;
		logic [7:0] req_led_left;
		logic [7:0] led_select;
		logic [7:0] led_select_state;
	} item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] led_right;
		logic [1:0] led_left;
		logic       button_right;
		logic       button_left;
		logic       lit_right;
		logic       lit_left;
	} result_t;

	typedef struct packed {
		logic       level;
		logic [7:0] lock;
		logic [1:0] led;
	} btn_t;

	// Handshake between the input register and the result register.
	typedef struct packed {
		logic fire;
		logic out_free;
	} flow_t;

	function automatic logic led_lit(input logic [1:0] code);
		return (code == LED_AT_ON) || (code == LED_ON);
	endfunction

	// One debounce step for one button: lockout, level change, auto toggle.
	function automatic btn_t btn_step(input btn_t cur, input logic pin,
			input logic [7:0] ticks);
		btn_t nxt;
		nxt = cur;
		if (cur.lock != 8'd0) begin
			nxt.lock = cur.lock - 8'd1;
		end else if (pin != cur.level) begin
			nxt.level = pin;
			nxt.lock  = ticks;
			if (pin == BTN_PRESSED) begin
				if (cur.led == LED_AT_OFF) begin
					nxt.led = LED_AT_ON;
				end else if (cur.led == LED_AT_ON) begin
					nxt.led = LED_AT_OFF;
				end
			end
		end
		return nxt;
	endfunction

endpackage

### src/dbl_if.sv
// Channel interfaces for the dual button debounce and LED toggle block.
// Command words, result words and the debounce register write channel.
// No dependencies.
interface dbl_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic       calc_phase;
	logic       message_phase;
	logic       pin_right;
	logic       pin_left;
	logic [7:0] req_led_right;
	logic [7:0] req_led_left;
	logic [7:0] led_select;
	logic [7:0] led_select_state;

	modport source (output valid, func, calc_phase, message_phase, pin_right, pin_left,
		req_led_right, req_led_left, led_select, led_select_state, input ready);
	modport sink (input valid, func, calc_phase, message_phase, pin_right, pin_left,
		req_led_right, req_led_left, led_select, led_select_state, output ready);
endinterface

interface dbl_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [1:0] led_right;
	logic [1:0] led_left;
	logic       button_right;
	logic       button_left;
	logic       lit_right;
	logic       lit_left;

	modport source (output valid, kind, led_right, led_left, button_right, button_left,
		lit_right, lit_left, input ready);
	modport sink (input valid, kind, led_right, led_left, button_right, button_left,
		lit_right, lit_left, output ready);
endinterface

interface dbl_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### src/dbl_in_reg.sv
// Input register: holds one accepted command word until the core takes it.
// Depends on dbl_pkg and dbl_in_if.
module dbl_in_reg
	import dbl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	dbl_in_if.sink      cmd,
	input  logic        out_free,
	output item_t       item_s1,
	output logic        fire
);
	logic valid_s1;

	assign fire      = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= '{func: cmd.func, calc_phase: cmd.calc_phase,
				message_phase: cmd.message_phase, pin_right: cmd.pin_right,
				pin_left: cmd.pin_left, req_led_right: cmd.req_led_right,
				req_led_left: cmd.req_led_left, led_select: cmd.led_select,
				led_select_state: cmd.led_select_state};
		end
	end
endmodule

### src/dbl_core.sv
// Button, lockout, LED and pending-event state with its single-pass update.
// Depends on dbl_pkg.
module dbl_core
	import dbl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item_s1,
	input  logic       fire,
	input  logic [7:0] debounce_ticks,
	output result_t    res,
	output logic       res_valid
);
	btn_t btn_r_q, btn_l_q;
	logic pending_q;

	btn_t btn_r_d, btn_l_d, step_r, step_l;
	logic pending_d;
	logic emit;
	logic [2:0] kind;

	assign step_r = btn_step(btn_r_q, item_s1.pin_right, debounce_ticks);
	assign step_l = btn_step(btn_l_q, item_s1.pin_left, debounce_ticks);

	always_comb begin
		btn_r_d   = btn_r_q;
		btn_l_d   = btn_l_q;
		pending_d = pending_q;
		emit      = 1'b1;
		kind      = KIND_ACK;
		unique case (item_s1.func)
			FUNC_TICK: begin
				emit = 1'b0;
				if (item_s1.calc_phase) begin
					btn_r_d = step_r;
					btn_l_d = step_l;
					if (step_r.level != btn_r_q.level || step_l.level != btn_l_q.level) begin
						pending_d = 1'b1;
					end
				end
				if (item_s1.message_phase && pending_d) begin
					pending_d = 1'b0;
					emit      = 1'b1;
					kind      = KIND_EVENT;
				end
			end
			FUNC_SET_BOTH: begin
				if (|item_s1.req_led_right[7:2] || |item_s1.req_led_left[7:2]) begin
					kind = KIND_INVALID;
				end else begin
					btn_r_d.led = item_s1.req_led_right[1:0];
					btn_l_d.led = item_s1.req_led_left[1:0];
				end
			end
			FUNC_SET_ONE: begin
				if (|item_s1.led_select_state[7:2]) begin
					kind = KIND_INVALID;
				end else if (item_s1.led_select == SEL_LEFT) begin
					btn_l_d.led = item_s1.led_select_state[1:0];
				end else if (item_s1.led_select == SEL_RIGHT) begin
					btn_r_d.led = item_s1.led_select_state[1:0];
				end else begin
					kind = KIND_INVALID;
				end
			end
			FUNC_GET_LEDS:    kind = KIND_LEDS;
			FUNC_GET_BUTTONS: kind = KIND_BUTTONS;
			default:          kind = KIND_UNSUPPORTED;
		endcase
	end

	assign res_valid = fire && emit;
	assign res = '{kind: kind, led_right: btn_r_d.led, led_left: btn_l_d.led,
		button_right: btn_r_d.level, button_left: btn_l_d.level,
		lit_right: led_lit(btn_r_d.led), lit_left: led_lit(btn_l_d.led)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_r_q   <= '{level: BTN_RELEASED, lock: 8'd0, led: LED_AT_OFF};
			btn_l_q   <= '{level: BTN_RELEASED, lock: 8'd0, led: LED_AT_OFF};
			pending_q <= 1'b0;
		end else if (fire) begin
			btn_r_q   <= btn_r_d;
			btn_l_q   <= btn_l_d;
			pending_q <= pending_d;
		end
	end
endmodule

### src/dbl_out_reg.sv
// Result register: holds one result word until the sink takes it.
// Depends on dbl_pkg and dbl_out_if.
module dbl_out_reg
	import dbl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  result_t res,
	input  logic    res_valid,
	output logic    out_free,
	dbl_out_if.source rsp
);
	result_t res_q;
	logic    valid_q;

	assign out_free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			res_q <= res;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.kind         = res_q.kind;
	assign rsp.led_right    = res_q.led_right;
	assign rsp.led_left     = res_q.led_left;
	assign rsp.button_right = res_q.button_right;
	assign rsp.button_left  = res_q.button_left;
	assign rsp.lit_right    = res_q.lit_right;
	assign rsp.lit_left     = res_q.lit_left;
endmodule

### src/dual_button_debounce_led_toggle_top.sv
// Top level of the dual button debounce and LED toggle block.
// Depends on dbl_pkg, dbl_if, dbl_in_reg, dbl_core and dbl_out_reg.
//
//  channel | dir | word                                  | taken when
//  cmd     | in  | func, phases, pins, LED requests      | cmd.valid && cmd.ready
//  rsp     | out | kind, LED codes, buttons, lit flags   | rsp.valid && rsp.ready
//  cfg     | in  | debounce_ticks                        | cfg.valid && cfg.ready
//
// One command word per cycle while no stalled result holds it; each result is registered.
// The state update is one pass from the input register to the result register.
// Reset: buttons released, LEDs auto-toggle-off, lockouts zero, debounce_ticks 10.
// A stalled result holds the input register; cmd.ready drops only then.
// cfg.ready is always high.
module dual_button_debounce_led_toggle_top
	import dbl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	dbl_in_if.sink    cmd,
	dbl_out_if.source rsp,
	dbl_cfg_if.sink   cfg
);
	item_t      item_s1;
	result_t    res;
	logic       res_valid;
	flow_t      flow;
	logic [7:0] debounce_ticks_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_RESET;
		end else if (cfg.valid) begin
			debounce_ticks_q <= cfg.data;
		end
	end

	dbl_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.out_free (flow.out_free),
		.item_s1  (item_s1),
		.fire     (flow.fire)
	);

	dbl_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_s1        (item_s1),
		.fire           (flow.fire),
		.debounce_ticks (debounce_ticks_q),
		.res            (res),
		.res_valid      (res_valid)
	);

	dbl_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.res_valid (res_valid),
		.out_free  (flow.out_free),
		.rsp       (rsp)
	);
endmodule

### verif/tb.sv
// Testbench for dual_button_debounce_led_toggle_top: directed and random command words,
// each reply checked against a behavioural model of the debouncer and LED state.
// Depends on dbl_pkg, dbl_if and the RTL of the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dbl_pkg::*;

	localparam logic [1:0] LED_OFF_CODE     = 2'd3;
	localparam logic [7:0] LED_CODE_MAX     = 8'd3;
	localparam logic [2:0] FUNC_FIRST_SPARE = 3'd5;
	localparam logic [2:0] FUNC_LAST_SPARE  = 3'd7;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 400;
	localparam int MAX_SHOWN     = 10;

	typedef struct packed {
		logic       level;
		logic [7:0] lock;
		logic [1:0] led;
	} key_t;

	logic clk = 1'b0;
	logic arst_n;

	dbl_in_if  cmd ();
	dbl_out_if rsp ();
	dbl_cfg_if cfg ();

	dual_button_debounce_led_toggle_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	key_t       key_right;
	key_t       key_left;
	logic       change_seen;
	logic [7:0] lockout_ticks;
	result_t    reply_q[$];

	int fail_count = 0;
	int shown = 0;
	bit gaps_on = 1'b1;
	int hold_requests = 0;
	logic phys_right = 1'b1;
	logic phys_left = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic key_t debounce_key(input key_t k, input logic pin, output logic moved);
		key_t n;
		n = k;
		moved = 1'b0;
		if (k.lock != 8'd0) begin
			n.lock = k.lock - 8'd1;
		end else if (pin != k.level) begin
			n.level = pin;
			n.lock  = lockout_ticks;
			moved   = 1'b1;
			if (pin == BTN_PRESSED) begin
				if (k.led == LED_AT_OFF) begin
					n.led = LED_AT_ON;
				end else if (k.led == LED_AT_ON) begin
					n.led = LED_AT_OFF;
				end
			end
		end
		return n;
	endfunction

	function automatic void predict_reply(input item_t w);
		logic    moved_r, moved_l;
		bit      emit;
		logic [2:0] kind;
		result_t r;
		emit = 1'b1;
		kind = KIND_UNSUPPORTED;
		case (w.func)
			FUNC_TICK: begin
				emit = 1'b0;
				if (w.calc_phase) begin
					key_right = debounce_key(key_right, w.pin_right, moved_r);
					key_left  = debounce_key(key_left, w.pin_left, moved_l);
					if (moved_r || moved_l) begin
						change_seen = 1'b1;
					end
				end
				if (w.message_phase && change_seen) begin
					change_seen = 1'b0;
					emit = 1'b1;
					kind = KIND_EVENT;
				end
			end
			FUNC_SET_BOTH: begin
				if (w.req_led_right > LED_CODE_MAX || w.req_led_left > LED_CODE_MAX) begin
					kind = KIND_INVALID;
				end else begin
					key_right.led = w.req_led_right[1:0];
					key_left.led  = w.req_led_left[1:0];
					kind = KIND_ACK;
				end
			end
			FUNC_SET_ONE: begin
				if (w.led_select_state > LED_CODE_MAX ||
						(w.led_select != SEL_LEFT && w.led_select != SEL_RIGHT)) begin
					kind = KIND_INVALID;
				end else begin
					if (w.led_select == SEL_LEFT) begin
						key_left.led = w.led_select_state[1:0];
					end else begin
						key_right.led = w.led_select_state[1:0];
					end
					kind = KIND_ACK;
				end
			end
			FUNC_GET_LEDS: kind = KIND_LEDS;
			FUNC_GET_BUTTONS: kind = KIND_BUTTONS;
			default: kind = KIND_UNSUPPORTED;
		endcase
		if (emit) begin
			r.kind         = kind;
			r.led_right    = key_right.led;
			r.led_left     = key_left.led;
			r.button_right = key_right.level;
			r.button_left  = key_left.level;
			r.lit_right    = (key_right.led == LED_AT_ON) || (key_right.led == LED_ON);
			r.lit_left     = (key_left.led == LED_AT_ON) || (key_left.led == LED_ON);
			reply_q.push_back(r);
		end
	endfunction

	function automatic item_t noise_word();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[$bits(item_t)-1:0];
	endfunction

	function automatic item_t tick_word(input logic calc, input logic msg,
			input logic pr, input logic pl);
		item_t w;
		w = noise_word();
		w.func          = FUNC_TICK;
		w.calc_phase    = calc;
		w.message_phase = msg;
		w.pin_right     = pr;
		w.pin_left      = pl;
		return w;
	endfunction

	function automatic item_t cmd_word(input logic [2:0] func, input logic [7:0] rr,
			input logic [7:0] rl, input logic [7:0] sel, input logic [7:0] ss);
		item_t w;
		w = noise_word();
		w.func             = func;
		w.req_led_right    = rr;
		w.req_led_left     = rl;
		w.led_select       = sel;
		w.led_select_state = ss;
		return w;
	endfunction

	function automatic logic [7:0] led_request();
		if ($urandom_range(99) < 85) begin
			return 8'($urandom_range(3));
		end
		return 8'($urandom());
	endfunction

	function automatic item_t random_word();
		item_t w;
		int pick;
		w = noise_word();
		pick = $urandom_range(99);
		if (pick < 55) begin
			if ($urandom_range(5) == 0) begin
				phys_right = ~phys_right;
			end
			if ($urandom_range(5) == 0) begin
				phys_left = ~phys_left;
			end
			w.func          = FUNC_TICK;
			w.calc_phase    = (pick < 45) ? 1'b1 : 1'($urandom());
			w.message_phase = 1'($urandom());
			w.pin_right     = ($urandom_range(19) == 0) ? 1'($urandom()) : phys_right;
			w.pin_left      = ($urandom_range(19) == 0) ? 1'($urandom()) : phys_left;
		end else if (pick < 70) begin
			w.func          = FUNC_SET_BOTH;
			w.req_led_right = led_request();
			w.req_led_left  = led_request();
		end else if (pick < 85) begin
			w.func             = FUNC_SET_ONE;
			w.led_select       = ($urandom_range(99) < 85) ? 8'($urandom_range(1)) :
				8'($urandom());
			w.led_select_state = led_request();
		end else if (pick < 92) begin
			w.func = FUNC_GET_LEDS;
		end else if (pick < 97) begin
			w.func = FUNC_GET_BUTTONS;
		end else begin
			w.func = 3'($urandom_range(FUNC_LAST_SPARE, FUNC_FIRST_SPARE));
		end
		return w;
	endfunction

	task automatic send_word(input item_t w);
		if (gaps_on && $urandom_range(99) < 26) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
			while (gaps_on && $urandom_range(99) < 26) begin
				@(posedge clk);
			end
		end
		cmd.valid            <= 1'b1;
		cmd.func             <= w.func;
		cmd.calc_phase       <= w.calc_phase;
		cmd.message_phase    <= w.message_phase;
		cmd.pin_right        <= w.pin_right;
		cmd.pin_left         <= w.pin_left;
		cmd.req_led_right    <= w.req_led_right;
		cmd.req_led_left     <= w.req_led_left;
		cmd.led_select       <= w.led_select;
		cmd.led_select_state <= w.led_select_state;
		@(posedge clk);
		while (!cmd.ready) begin
			@(posedge clk);
		end
		predict_reply(w);
	endtask

	task automatic settle();
		cmd.valid <= 1'b0;
		while (reply_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ticks(input logic [7:0] v);
		settle();
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		@(posedge clk);
		while (!cfg.ready) begin
			@(posedge clk);
		end
		cfg.valid <= 1'b0;
		lockout_ticks = v;
	endtask

	task automatic test_directed();
		send_word(cmd_word(FUNC_GET_LEDS, 8'd0, 8'd0, 8'd0, 8'd0));
		send_word(cmd_word(FUNC_GET_BUTTONS, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_word(cmd_word(FUNC_FIRST_SPARE, 8'd0, 8'd0, SEL_LEFT, 8'd0));
		send_word(cmd_word(FUNC_FIRST_SPARE + 3'd1, 8'd1, 8'd2, SEL_RIGHT, 8'd3));
		send_word(cmd_word(FUNC_LAST_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_word(cmd_word(FUNC_SET_BOTH, LED_CODE_MAX + 8'd1, 8'd0, 8'd0, 8'd0));
		send_word(cmd_word(FUNC_SET_BOTH, 8'd0, 8'hFF, 8'd0, 8'd0));
		send_word(cmd_word(FUNC_SET_BOTH, 8'd0, 8'd0, 8'd0, 8'd0));
		send_word(cmd_word(FUNC_SET_BOTH, {6'd0, LED_OFF_CODE}, {6'd0, LED_ON}, 8'd0, 8'd0));
		send_word(cmd_word(FUNC_SET_ONE, 8'd0, 8'd0, SEL_RIGHT + 8'd1, 8'd0));
		send_word(cmd_word(FUNC_SET_ONE, 8'd0, 8'd0, 8'hFF, 8'd1));
		send_word(cmd_word(FUNC_SET_ONE, 8'd0, 8'd0, SEL_LEFT, LED_CODE_MAX + 8'd1));
		send_word(cmd_word(FUNC_SET_ONE, 8'd0, 8'd0, SEL_RIGHT, 8'hFF));
		send_word(cmd_word(FUNC_GET_LEDS, 8'd0, 8'd0, 8'd0, 8'd0));
		send_word(tick_word(1'b0, 1'b0, BTN_PRESSED, BTN_PRESSED));
		send_word(tick_word(1'b0, 1'b1, BTN_PRESSED, BTN_PRESSED));
		send_word(tick_word(1'b1, 1'b1, BTN_PRESSED, BTN_PRESSED));
		send_word(tick_word(1'b1, 1'b1, BTN_RELEASED, BTN_RELEASED));
		send_word(cmd_word(FUNC_GET_BUTTONS, 8'd0, 8'd0, 8'd0, 8'd0));
		send_word(cmd_word(FUNC_SET_BOTH, {6'd0, LED_AT_OFF}, {6'd0, LED_AT_ON}, 8'd0, 8'd0));
		send_word(cmd_word(FUNC_SET_ONE, 8'd0, 8'd0, SEL_LEFT, {6'd0, LED_AT_OFF}));
		send_word(cmd_word(FUNC_SET_ONE, 8'd0, 8'd0, SEL_RIGHT, LED_CODE_MAX));
	endtask

	task automatic test_zero_lockout();
		write_ticks(8'd0);
		repeat (150) begin
			if ($urandom_range(9) == 0) begin
				send_word(cmd_word(FUNC_GET_BUTTONS, 8'($urandom()), 8'($urandom()),
					8'($urandom()), 8'($urandom())));
			end else begin
				send_word(tick_word(1'($urandom_range(3) != 0), 1'($urandom()),
					1'($urandom()), 1'($urandom())));
			end
		end
	endtask

	task automatic test_long_lockout();
		write_ticks(8'd255);
		send_word(cmd_word(FUNC_SET_BOTH, {6'd0, LED_AT_OFF}, {6'd0, LED_AT_ON}, 8'd0, 8'd0));
		send_word(tick_word(1'b1, 1'b1, BTN_PRESSED, BTN_RELEASED));
		send_word(tick_word(1'b1, 1'b1, BTN_RELEASED, BTN_PRESSED));
		repeat (262) begin
			send_word(tick_word(1'b1, 1'($urandom()), 1'($urandom()), 1'($urandom())));
		end
		send_word(tick_word(1'b1, 1'b1, BTN_PRESSED, BTN_PRESSED));
		send_word(cmd_word(FUNC_GET_LEDS, 8'd0, 8'd0, 8'd0, 8'd0));
	endtask

	task automatic test_random_settings();
		logic [7:0] setting[5];
		setting = '{8'd1, 8'd0, 8'd3, 8'd255, 8'd2};
		setting[4] = 8'($urandom_range(16, 2));
		foreach (setting[i]) begin
			write_ticks(setting[i]);
			repeat (220) send_word(random_word());
		end
	endtask

	task automatic test_no_gaps();
		write_ticks(8'($urandom_range(6, 1)));
		gaps_on = 1'b0;
		repeat (200) send_word(random_word());
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		settle();
		gaps_on = 1'b0;
		hold_requests++;
		repeat (60) send_word(random_word());
		gaps_on = 1'b1;
	endtask

	initial begin : drive_ready
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (gaps_on && $urandom_range(99) < 26) begin
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_replies
		result_t got;
		result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.kind         = rsp.kind;
			got.led_right    = rsp.led_right;
			got.led_left     = rsp.led_left;
			got.button_right = rsp.button_right;
			got.button_left  = rsp.button_left;
			got.lit_right    = rsp.lit_right;
			got.lit_left     = rsp.lit_left;
			if (reply_q.size() == 0) begin
				fail_count++;
				if (shown < MAX_SHOWN) begin
					shown++;
					$display("%0t: reply word %h with none outstanding", $realtime, got);
				end
			end else begin
				want = reply_q.pop_front();
				if (got !== want) begin
					fail_count++;
					if (shown < MAX_SHOWN) begin
						shown++;
						$display("%0t: reply mismatch kind %0d/%0d led r %0d/%0d l %0d/%0d",
							$realtime, want.kind, got.kind, want.led_right, got.led_right,
							want.led_left, got.led_left);
						$display("    button r %b/%b l %b/%b lit r %b/%b l %b/%b",
							want.button_right, got.button_right, want.button_left,
							got.button_left, want.lit_right, got.lit_right,
							want.lit_left, got.lit_left);
					end
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) ||
					(cfg.valid && cfg.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
		$display("FAIL dual_button_debounce_led_toggle_top");
		$finish;
	end

	initial begin : run
		key_right     = '{level: BTN_RELEASED, lock: 8'd0, led: LED_AT_OFF};
		key_left      = '{level: BTN_RELEASED, lock: 8'd0, led: LED_AT_OFF};
		change_seen   = 1'b0;
		lockout_ticks = DEBOUNCE_RESET;
		arst_n               <= 1'b0;
		cmd.valid            <= 1'b0;
		cmd.func             <= FUNC_TICK;
		cmd.calc_phase       <= 1'b0;
		cmd.message_phase    <= 1'b0;
		cmd.pin_right        <= BTN_RELEASED;
		cmd.pin_left         <= BTN_RELEASED;
		cmd.req_led_right    <= 8'd0;
		cmd.req_led_left     <= 8'd0;
		cmd.led_select       <= 8'd0;
		cmd.led_select_state <= 8'd0;
		cfg.valid            <= 1'b0;
		cfg.data             <= 8'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_zero_lockout();
		test_long_lockout();
		test_random_settings();
		test_no_gaps();
		test_backpressure();

		settle();
		repeat (8) @(posedge clk);
		if (reply_q.size() != 0) begin
			fail_count += reply_q.size();
			$display("%0d expected replies never arrived", reply_q.size());
		end
		if (fail_count == 0) begin
			$display("PASS dual_button_debounce_led_toggle_top");
		end else begin
			$display("FAIL dual_button_debounce_led_toggle_top");
		end
		$finish;
	end

endmodule
